// File: src/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies consequence in the next cycle.
`define S2C_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle property");

// Condition implies consequence in the same cycle.
`define S2C_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle property");

`endif

// File: src/s2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2c_pkg
// Widths, constants and shared types of the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package s2c_pkg;

   localparam int SECS_W    = 62;   // seconds after the epoch offset is removed
   localparam int TOD_W     = 17;   // seconds within a day
   localparam int DAYS_W    = 46;   // whole-day count
   localparam int EST_W     = 60;   // numerator of the year estimate
   localparam int YEAR_W    = 38;
   localparam int BASE_W    = 47;
   localparam int REM_W     = 10;   // day within a March-based year
   localparam int MI_W      = 6;
   localparam int MI_N_W    = 17;
   localparam int FIELD_W   = 38;
   localparam int SEL_W     = 3;
   localparam int DIV_STEPS = 8;    // quotient bits resolved per stage

   localparam logic [TOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
   localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0]       SECS_PER_MIN  = 12'd60;
   localparam logic [DAYS_W-1:0] DAY_SHIFT     = 46'd719468;
   localparam logic [13:0]       EST_MUL       = 14'd10000;
   localparam logic [EST_W-1:0]  EST_ADD       = 60'd14780;
   localparam logic [21:0]       EST_DIV       = 22'd3652425;
   localparam logic [6:0]        CENTURY       = 7'd100;
   localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;
   localparam logic [6:0]        MI_MUL        = 7'd100;
   localparam logic [MI_N_W-1:0] MI_ADD        = 17'd52;
   localparam logic [MI_N_W-1:0] MI_DIV        = 17'd3060;
   localparam logic [MI_W-1:0]   MONTHS        = 6'd12;

   typedef enum logic [SEL_W-1:0] {
      SEL_YEAR   = 3'd0,
      SEL_MONTH  = 3'd1,
      SEL_DAY    = 3'd2,
      SEL_HOUR   = 3'd3,
      SEL_MINUTE = 3'd4,
      SEL_SECOND = 3'd5
   } sel_type;

   typedef struct packed {
      logic [SEL_W-1:0] sel;
      logic [4:0]       hour;
      logic [5:0]       minute;
      logic [5:0]       second;
   } side_type;

   // Days before the start of March-based month mi: (306*mi + 5) / 10.
   function automatic logic [8:0] month_start(input logic [3:0] mi);
      logic [8:0] d;
      unique case (mi)
         4'd0:  d = 9'd0;
         4'd1:  d = 9'd31;
         4'd2:  d = 9'd61;
         4'd3:  d = 9'd92;
         4'd4:  d = 9'd122;
         4'd5:  d = 9'd153;
         4'd6:  d = 9'd184;
         4'd7:  d = 9'd214;
         4'd8:  d = 9'd245;
         4'd9:  d = 9'd275;
         4'd10: d = 9'd306;
         4'd11: d = 9'd337;
         4'd12: d = 9'd367;
         4'd13: d = 9'd398;
         4'd14: d = 9'd428;
         4'd15: d = 9'd459;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: src/seconds_to_calendar_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_field
// Converts an offset timestamp in seconds to one Gregorian calendar field.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata                      | tuser
//   --------+-----+----------------------------+---------------------------
//   req_    | in  | [62:0] tai_seconds         | [2:0] component_select
//   rsp_    | out | [37:0] field_value         | -
//
// One word enters per cycle and one result word leaves per cycle while the
// result is not stalled; the pipeline depth comes mostly from the three
// long-division chains (86400, 3652425, 100) that resolve eight quotient bits per stage.
// Reset clears every valid bit; payload registers are not reset.
// A stalled result freezes the whole pipeline in place, so req_tready falls
// in the same cycle and no word is dropped or repeated.
//
module seconds_to_calendar_field (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] tai_seconds, [63] zero pad
   input  logic [2:0]  req_tuser,   // [2:0] component_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [37:0] field_value, [39:38] zero pad
);
   import s2c_pkg::*;

   // Output register: hold the word until the sink takes it.
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_data_ff;

   // Pipeline moves as one whenever the output register is empty or drains.
   logic adv;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Input stage: drop the epoch offset, clamp anything earlier to zero.
   logic              in_valid_ff;
   logic [SECS_W-1:0] secs_in, secs_ff;
   logic [SEL_W-1:0]  sel_ff;

   assign secs_in = req_tdata[SECS_W] ? req_tdata[SECS_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         secs_ff <= secs_in;
         sel_ff  <= req_tuser;
      end
   end

   // Day count and time of day.
   logic              days_valid;
   logic [DAYS_W-1:0] days;
   side_type          days_side;

   s2c_days u_days (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid_ff),
      .in_secs   (secs_ff),
      .in_sel    (sel_ff),
      .out_valid (days_valid),
      .out_days  (days),
      .out_side  (days_side)
   );

   // Year estimate.
   logic              est_valid;
   logic [YEAR_W-1:0] est_year;
   logic [DAYS_W-1:0] est_g;
   side_type          est_side;

   s2c_year u_year (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (days_valid),
      .in_days   (days),
      .in_side   (days_side),
      .out_valid (est_valid),
      .out_year  (est_year),
      .out_g     (est_g),
      .out_side  (est_side)
   );

   // Corrected year, day of year and month index.
   logic              date_valid;
   logic [YEAR_W-1:0] date_year;
   logic [REM_W-1:0]  date_rem;
   logic [MI_W-1:0]   date_mi;
   side_type          date_side;

   s2c_date u_date (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (est_valid),
      .in_year   (est_year),
      .in_g      (est_g),
      .in_side   (est_side),
      .out_valid (date_valid),
      .out_year  (date_year),
      .out_rem   (date_rem),
      .out_mi    (date_mi),
      .out_side  (date_side)
   );

   // Final stage: month from the March-based index, roll the year for
   // January and February, day of month, then pick the field.
   logic [MI_W-1:0]    m2, month;
   logic               roll;
   logic [YEAR_W-1:0]  year;
   logic [REM_W-1:0]   mday;
   logic [FIELD_W-1:0] field_in;

   always_comb begin
      m2 = date_mi + MI_W'(2);
      if (m2 >= MONTHS) begin
         roll  = 1'b1;
         month = m2 - MONTHS + MI_W'(1);
      end else begin
         roll  = 1'b0;
         month = m2 + MI_W'(1);
      end
      year = date_year + YEAR_W'(roll);
      mday = date_rem - REM_W'(month_start(date_mi[3:0])) + REM_W'(1);

      unique case (date_side.sel)
         SEL_YEAR:   field_in = year;
         SEL_MONTH:  field_in = FIELD_W'(month);
         SEL_DAY:    field_in = FIELD_W'(mday);
         SEL_HOUR:   field_in = FIELD_W'(date_side.hour);
         SEL_MINUTE: field_in = FIELD_W'(date_side.minute);
         SEL_SECOND: field_in = FIELD_W'(date_side.second);
         default:    field_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= date_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= field_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

// File: src/s2c_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2c_days
// Long division of the seconds count by 86400, then hour/minute/second split.
// ----------------------------------------------------------------------------
module s2c_days (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [s2c_pkg::SECS_W-1:0]   in_secs,
   input  logic [s2c_pkg::SEL_W-1:0]    in_sel,
   output logic                         out_valid,
   output logic [s2c_pkg::DAYS_W-1:0]   out_days,
   output s2c_pkg::side_type            out_side
);
   import s2c_pkg::*;

   localparam int DS   = (SECS_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NQ_W = DS * DIV_STEPS;

   logic [NQ_W-1:0]  nq_src  [DS];
   logic [NQ_W-1:0]  nq_in   [DS];
   logic [NQ_W-1:0]  nq_ff   [DS];
   logic [TOD_W-1:0] rem_src [DS];
   logic [TOD_W-1:0] rem_in  [DS];
   logic [TOD_W-1:0] rem_ff  [DS];
   logic [SEL_W-1:0] sel_src [DS];
   logic [SEL_W-1:0] sel_ff  [DS];
   logic             v_src   [DS];
   logic             v_ff    [DS];

   assign nq_src[0]  = {{(NQ_W - SECS_W){1'b0}}, in_secs};
   assign rem_src[0] = '0;
   assign sel_src[0] = in_sel;
   assign v_src[0]   = in_valid;

   for (genvar k = 1; k < DS; k++) begin : g_link
      assign nq_src[k]  = nq_ff[k-1];
      assign rem_src[k] = rem_ff[k-1];
      assign sel_src[k] = sel_ff[k-1];
      assign v_src[k]   = v_ff[k-1];
   end

   for (genvar k = 0; k < DS; k++) begin : g_div
      always_comb begin
         logic [TOD_W:0]   t;
         logic [NQ_W-1:0]  w;
         logic [TOD_W-1:0] r;
         r = rem_src[k];
         w = nq_src[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            t = {r, w[NQ_W-1]};
            w = {w[NQ_W-2:0], 1'b0};
            if (t >= {1'b0, SECS_PER_DAY}) begin
               t    = t - {1'b0, SECS_PER_DAY};
               w[0] = 1'b1;
            end
            r = t[TOD_W-1:0];
         end
         nq_in[k]  = w;
         rem_in[k] = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[k]  <= nq_in[k];
            rem_ff[k] <= rem_in[k];
            sel_ff[k] <= sel_src[k];
         end
      end
   end

   // hour split
   logic              va_ff;
   logic [DAYS_W-1:0] days_a_ff;
   logic [SEL_W-1:0]  sel_a_ff;
   logic [4:0]        hour_in, hour_a_ff;
   logic [11:0]       rs_in, rs_a_ff;

   always_comb begin
      logic [TOD_W-1:0] r;
      r       = rem_ff[DS-1];
      hour_in = '0;
      for (int j = 4; j >= 0; j--) begin
         if (r >= (SECS_PER_HOUR << j)) begin
            r          = r - (SECS_PER_HOUR << j);
            hour_in[j] = 1'b1;
         end
      end
      rs_in = r[11:0];
   end

   // minute and second split
   logic       vb_ff;
   logic [DAYS_W-1:0] days_b_ff;
   side_type   side_in, side_b_ff;

   always_comb begin
      logic [11:0] r;
      r              = rs_a_ff;
      side_in.sel    = sel_a_ff;
      side_in.hour   = hour_a_ff;
      side_in.minute = '0;
      for (int j = 5; j >= 0; j--) begin
         if (r >= (SECS_PER_MIN << j)) begin
            r                 = r - (SECS_PER_MIN << j);
            side_in.minute[j] = 1'b1;
         end
      end
      side_in.second = r[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= v_ff[DS-1];
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         days_a_ff <= nq_ff[DS-1][DAYS_W-1:0];
         sel_a_ff  <= sel_ff[DS-1];
         hour_a_ff <= hour_in;
         rs_a_ff   <= rs_in;
         days_b_ff <= days_a_ff;
         side_b_ff <= side_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_days  = days_b_ff;
   assign out_side  = side_b_ff;

endmodule

// File: src/s2c_year.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2c_year
// Shift the day count to a March epoch and estimate the year by long
// division of (10000*g + 14780) by 3652425.
// ----------------------------------------------------------------------------
module s2c_year (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [s2c_pkg::DAYS_W-1:0]   in_days,
   input  s2c_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [s2c_pkg::YEAR_W-1:0]   out_year,
   output logic [s2c_pkg::DAYS_W-1:0]   out_g,
   output s2c_pkg::side_type            out_side
);
   import s2c_pkg::*;

   localparam int DS    = (EST_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NQ_W  = DS * DIV_STEPS;
   localparam int DR_W  = 22;

   // front: day shift and scaled numerator
   logic              v0_ff;
   logic [DAYS_W-1:0] g_in, g0_ff;
   logic [EST_W-1:0]  est_in, est0_ff;
   side_type          side0_ff;

   assign g_in   = in_days + DAY_SHIFT;
   assign est_in = EST_W'(g_in) * EST_W'(EST_MUL) + EST_ADD;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g0_ff    <= g_in;
         est0_ff  <= est_in;
         side0_ff <= in_side;
      end
   end

   logic [NQ_W-1:0]   nq_src  [DS];
   logic [NQ_W-1:0]   nq_in   [DS];
   logic [NQ_W-1:0]   nq_ff   [DS];
   logic [DR_W-1:0]   rem_src [DS];
   logic [DR_W-1:0]   rem_in  [DS];
   logic [DR_W-1:0]   rem_ff  [DS];
   logic [DAYS_W-1:0] g_src   [DS];
   logic [DAYS_W-1:0] g_ff    [DS];
   side_type          sd_src  [DS];
   side_type          sd_ff   [DS];
   logic              v_src   [DS];
   logic              v_ff    [DS];

   assign nq_src[0]  = {{(NQ_W - EST_W){1'b0}}, est0_ff};
   assign rem_src[0] = '0;
   assign g_src[0]   = g0_ff;
   assign sd_src[0]  = side0_ff;
   assign v_src[0]   = v0_ff;

   for (genvar k = 1; k < DS; k++) begin : g_link
      assign nq_src[k]  = nq_ff[k-1];
      assign rem_src[k] = rem_ff[k-1];
      assign g_src[k]   = g_ff[k-1];
      assign sd_src[k]  = sd_ff[k-1];
      assign v_src[k]   = v_ff[k-1];
   end

   for (genvar k = 0; k < DS; k++) begin : g_div
      always_comb begin
         logic [DR_W:0]   t;
         logic [NQ_W-1:0] w;
         logic [DR_W-1:0] r;
         r = rem_src[k];
         w = nq_src[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            t = {r, w[NQ_W-1]};
            w = {w[NQ_W-2:0], 1'b0};
            if (t >= {1'b0, EST_DIV}) begin
               t    = t - {1'b0, EST_DIV};
               w[0] = 1'b1;
            end
            r = t[DR_W-1:0];
         end
         nq_in[k]  = w;
         rem_in[k] = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[k]  <= nq_in[k];
            rem_ff[k] <= rem_in[k];
            g_ff[k]   <= g_src[k];
            sd_ff[k]  <= sd_src[k];
         end
      end
   end

   assign out_valid = v_ff[DS-1];
   assign out_year  = nq_ff[DS-1][YEAR_W-1:0];
   assign out_g     = g_ff[DS-1];
   assign out_side  = sd_ff[DS-1];

endmodule

// File: src/s2c_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2c_date
// Year correction and month index: divide the year estimate by 100, form the
// days before the estimated year and the year before it, pick one, then
// divide the day-of-year term by 3060.
// ----------------------------------------------------------------------------
module s2c_date (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [s2c_pkg::YEAR_W-1:0]   in_year,
   input  logic [s2c_pkg::DAYS_W-1:0]   in_g,
   input  s2c_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [s2c_pkg::YEAR_W-1:0]   out_year,
   output logic [s2c_pkg::REM_W-1:0]    out_rem,
   output logic [s2c_pkg::MI_W-1:0]     out_mi,
   output s2c_pkg::side_type            out_side
);
   import s2c_pkg::*;

   localparam int DS   = (YEAR_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NQ_W = DS * DIV_STEPS;
   localparam int CR_W = 7;

   function automatic logic [BASE_W-1:0] days_before(input logic [YEAR_W-1:0] y,
                                                     input logic [YEAR_W-1:0] q);
      return BASE_W'(y) * BASE_W'(DAYS_PER_YEAR) + BASE_W'(y >> 2)
             - BASE_W'(q) + BASE_W'(q >> 2);
   endfunction

   logic [NQ_W-1:0]   nq_src  [DS];
   logic [NQ_W-1:0]   nq_in   [DS];
   logic [NQ_W-1:0]   nq_ff   [DS];
   logic [CR_W-1:0]   rem_src [DS];
   logic [CR_W-1:0]   rem_in  [DS];
   logic [CR_W-1:0]   rem_ff  [DS];
   logic [YEAR_W-1:0] y_src   [DS];
   logic [YEAR_W-1:0] y_ff    [DS];
   logic [DAYS_W-1:0] g_src   [DS];
   logic [DAYS_W-1:0] g_ff    [DS];
   side_type          sd_src  [DS];
   side_type          sd_ff   [DS];
   logic              v_src   [DS];
   logic              v_ff    [DS];

   assign nq_src[0]  = {{(NQ_W - YEAR_W){1'b0}}, in_year};
   assign rem_src[0] = '0;
   assign y_src[0]   = in_year;
   assign g_src[0]   = in_g;
   assign sd_src[0]  = in_side;
   assign v_src[0]   = in_valid;

   for (genvar k = 1; k < DS; k++) begin : g_link
      assign nq_src[k]  = nq_ff[k-1];
      assign rem_src[k] = rem_ff[k-1];
      assign y_src[k]   = y_ff[k-1];
      assign g_src[k]   = g_ff[k-1];
      assign sd_src[k]  = sd_ff[k-1];
      assign v_src[k]   = v_ff[k-1];
   end

   for (genvar k = 0; k < DS; k++) begin : g_div
      always_comb begin
         logic [CR_W:0]   t;
         logic [NQ_W-1:0] w;
         logic [CR_W-1:0] r;
         r = rem_src[k];
         w = nq_src[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            t = {r, w[NQ_W-1]};
            w = {w[NQ_W-2:0], 1'b0};
            if (t >= {1'b0, CENTURY}) begin
               t    = t - {1'b0, CENTURY};
               w[0] = 1'b1;
            end
            r = t[CR_W-1:0];
         end
         nq_in[k]  = w;
         rem_in[k] = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[k]  <= nq_in[k];
            rem_ff[k] <= rem_in[k];
            y_ff[k]   <= y_src[k];
            g_ff[k]   <= g_src[k];
            sd_ff[k]  <= sd_src[k];
         end
      end
   end

   // both candidate year starts; (y-1)/100 follows from the remainder
   logic              vc_ff, vd_ff, ve_ff;
   logic [YEAR_W-1:0] q0, q1, y1;
   logic [BASE_W-1:0] base0_in, base1_in, base0_ff, base1_ff;
   logic [YEAR_W-1:0] yc_ff;
   logic [DAYS_W-1:0] gc_ff;
   side_type          sc_ff, sd2_ff, se_ff;

   assign q0       = nq_ff[DS-1][YEAR_W-1:0];
   assign q1       = (rem_ff[DS-1] == '0) ? q0 - YEAR_W'(1) : q0;
   assign y1       = y_ff[DS-1] - YEAR_W'(1);
   assign base0_in = days_before(y_ff[DS-1], q0);
   assign base1_in = days_before(y1, q1);

   // correct the estimate by one year when it overshoots
   logic [YEAR_W-1:0] yd_in, yd_ff, ye_ff;
   logic [BASE_W-1:0] based;
   logic [REM_W-1:0]  remd_in, remd_ff, reme_ff;

   always_comb begin
      if (base0_ff > BASE_W'(gc_ff)) begin
         yd_in = yc_ff - YEAR_W'(1);
         based = base1_ff;
      end else begin
         yd_in = yc_ff;
         based = base0_ff;
      end
      remd_in = REM_W'(BASE_W'(gc_ff) - based);
   end

   // month index: (100*rem + 52) / 3060
   logic [MI_W-1:0] mi_in, mi_ff;

   always_comb begin
      logic [MI_N_W-1:0] n;
      n     = MI_N_W'(remd_ff) * MI_N_W'(MI_MUL) + MI_ADD;
      mi_in = '0;
      for (int j = MI_W - 1; j >= 0; j--) begin
         if (n >= (MI_DIV << j)) begin
            n        = n - (MI_DIV << j);
            mi_in[j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= v_ff[DS-1];
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         base0_ff <= base0_in;
         base1_ff <= base1_in;
         yc_ff    <= y_ff[DS-1];
         gc_ff    <= g_ff[DS-1];
         sc_ff    <= sd_ff[DS-1];
         yd_ff    <= yd_in;
         remd_ff  <= remd_in;
         sd2_ff   <= sc_ff;
         ye_ff    <= yd_ff;
         reme_ff  <= remd_ff;
         mi_ff    <= mi_in;
         se_ff    <= sd2_ff;
      end
   end

   assign out_valid = ve_ff;
   assign out_year  = ye_ff;
   assign out_rem   = reme_ff;
   assign out_mi    = mi_ff;
   assign out_side  = se_ff;

endmodule

// File: src/s2c_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2c_checker
// Port-level checks on the calendar pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s2c_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   // held result stays offered and unchanged
   `S2C_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `S2C_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // a stalled result stalls the intake in the same cycle
   `S2C_ASSERT_NOW(a_backpressure, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // padding above the field stays zero
   `S2C_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[39:38] == 2'b00)
endmodule

bind seconds_to_calendar_field s2c_checker u_s2c_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamps with every component select into the calendar pipeline,
// predicts each field from its own civil-date conversion and checks every
// result word in order against the predicted value.
// ----------------------------------------------------------------------------

class calendar_scoreboard;
   logic [37:0] pending_fields[$];
   int          mismatches;
   int          reported;

   // Predict the calendar field for one accepted timestamp.
   function automatic logic [37:0] calendar_field(logic [62:0] stamp, logic [2:0] sel);
      logic [63:0] secs, days, year, base, rem, mi, mon, day;
      logic [63:0] sec_v, min_v, hour_v;
      secs = (stamp >= 63'h4000000000000000) ? 64'(stamp) - 64'h4000000000000000 : 64'd0;
      sec_v = secs % 60; secs = secs / 60;
      min_v = secs % 60; secs = secs / 60;
      hour_v = secs % 24; secs = secs / 24;
      days = secs + 64'd719468;
      year = (64'd10000 * days + 64'd14780) / 64'd3652425;
      base = 365 * year + year / 4 - year / 100 + year / 400;
      if (base > days) begin
         year = year - 1;
         base = 365 * year + year / 4 - year / 100 + year / 400;
      end
      rem = days - base;
      mi = (100 * rem + 52) / 3060;
      mon = (mi + 2) % 12 + 1;
      year = year + (mi + 2) / 12;
      day = rem - (306 * mi + 5) / 10 + 1;
      case (sel)
         s2c_pkg::SEL_YEAR:   return year[37:0];
         s2c_pkg::SEL_MONTH:  return mon[37:0];
         s2c_pkg::SEL_DAY:    return day[37:0];
         s2c_pkg::SEL_HOUR:   return hour_v[37:0];
         s2c_pkg::SEL_MINUTE: return min_v[37:0];
         s2c_pkg::SEL_SECOND: return sec_v[37:0];
         default:             return 38'd0;
      endcase
   endfunction

   function void note_timestamp(logic [62:0] stamp, logic [2:0] sel);
      pending_fields.push_back(calendar_field(stamp, sel));
   endfunction

   function void check_field(logic [39:0] word);
      logic [37:0] want;
      if (pending_fields.size() == 0) begin
         mismatches++;
         if (reported < 10) begin
            reported++;
            $display("unexpected result word %h", word);
         end
         return;
      end
      want = pending_fields.pop_front();
      if (word[37:0] !== want || word[39:38] !== 2'b00) begin
         mismatches++;
         if (reported < 10) begin
            reported++;
            $display("field mismatch: expected %0d got %0d (word %h)", want, word[37:0], word);
         end
      end
   endfunction
endclass

module testbench;
   import s2c_pkg::*;

   localparam int LATENCY = 30;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   calendar_scoreboard board = new();
   bit stimulus_done = 1'b0;
   bit hold_rsp = 1'b0;
   int idle_cycles = 0;

   seconds_to_calendar_field i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic [62:0] random_stamp();
      logic [62:0] r;
      int pick;
      r = 63'({$urandom, $urandom});
      pick = $urandom_range(9);
      if (pick < 5) return 63'h4000000000000000 + (r & 63'hFFFFFFFFFF);   // near epoch
      if (pick < 7) return 63'h4000000000000000 | r;                      // far future
      if (pick < 8) return r & 63'h3FFFFFFFFFFFFFFF;                      // clamps
      return r;
   endfunction

   // Offer one word and hold it until the pipeline takes it.
   task automatic send_word(logic [62:0] stamp, logic [2:0] sel);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, stamp};
      req_tuser  <= sel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_timestamp(stamp, sel);
   endtask

   task automatic send_with_gap(logic [62:0] stamp, logic [2:0] sel);
      int gap;
      send_word(stamp, sel);
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_fields.size() != 0) @(posedge clock);
   endtask

   // Sender: directed corners first, then random timestamps.
   initial begin
      logic [62:0] corners[10];
      corners[0] = 63'd0;
      corners[1] = 63'h3FFFFFFFFFFFFFFF;                  // just below offset
      corners[2] = 63'h4000000000000000;                  // epoch
      corners[3] = 63'h4000000000000000 + 63'd951782399;  // 2000-02-28 23:59:59
      corners[4] = 63'h4000000000000000 + 63'd951868800;  // 2000-03-01 (leap year)
      corners[5] = 63'h4000000000000000 + 63'd4107542399; // 2100-02-28 end
      corners[6] = 63'h4000000000000000 + 63'd86399;
      corners[7] = 63'h4000000000000000 + 63'd946684799; // 1999-12-31 23:59:59
      corners[8] = 63'h7FFFFFFFFFFFFFFF;                  // largest timestamp
      corners[9] = 63'h5555555555555555;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 10; i++) begin
         send_word(corners[i], SEL_YEAR);
         send_word(corners[i], SEL_DAY);
         if (i == 3 || i == 8) begin
            for (int s = 1; s < 8; s++) send_word(corners[i], 3'(s));
         end
      end
      drain();
      // Long receiver hold-off while the sender keeps offering.
      hold_rsp = 1'b1;
      for (int i = 0; i < 80; i++) send_word(random_stamp(), 3'($urandom_range(7)));
      drain();
      for (int i = 0; i < 860; i++) begin
         if (i < 300 || i > 600) send_with_gap(random_stamp(), 3'($urandom_range(7)));
         else send_word(random_stamp(), 3'($urandom_range(7)));
      end
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      stimulus_done = 1'b1;
   end

   // Receiver: random back-pressure, plus one long stall on request.
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         gap = gap_length();
         if (gap > 0 && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Collect results and watch for a hung pipeline.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_field(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (stimulus_done || idle_cycles >= STALL_LIMIT);
      if (stimulus_done && board.mismatches == 0 && board.pending_fields.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+src
src/s2c_pkg.sv
src/s2c_days.sv
src/s2c_year.sv
src/s2c_date.sv
src/seconds_to_calendar_field.sv
src/s2c_checker.sv
bench/testbench.sv
